// File: design/store_dependence_path_table_top_macros.svh
// assertion macros used by the store dependence path table controller
// depends on nothing
`ifndef STORE_DEPENDENCE_PATH_TABLE_TOP_MACROS_SVH
`define STORE_DEPENDENCE_PATH_TABLE_TOP_MACROS_SVH
// implication checked every clock outside reset
`define SDPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdpt check failed");
// next-cycle implication checked outside reset
`define SDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdpt check failed");
`endif

// File: design/sdpt_pkg.sv
// package for the store dependence path table: sizes, codes, hash functions
// used by controller, datapath and top level
package sdpt_pkg;
    localparam int SET_W = 7;
    localparam int TAG_W = 12;
    localparam int WAYS = 4;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_CHUNKS = (64 + SET_W - 1) / SET_W;
    localparam int TAG_CHUNKS = (64 + TAG_W - 1) / TAG_W;
    localparam logic [3:0] CMAX_RESET = 4'd3;

    typedef enum logic [1:0] {
        CMD_PREDICT = 2'd0,
        CMD_VIOLATION = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_CLEAR = 4'b1000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic clr_wr;
        logic [SET_W-1:0] clr_set;
    } t_ctl;

    // fold 64 bits into SET_W by xor of chunks
    function automatic logic [SET_W-1:0] set_of(input logic [63:0] pc,
                                                input logic [63:0] hash);
        logic [63:0] v;
        logic [SET_W-1:0] acc;
        v = pc ^ (pc >> 2) ^ (pc >> 5) ^ hash;
        acc = '0;
        for (int i = 0; i < SET_CHUNKS; i++) begin
            acc = acc ^ SET_W'(v >> (i * SET_W));
        end
        return acc;
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [63:0] pc,
                                                input logic [63:0] hash);
        logic [63:0] v;
        logic [TAG_W-1:0] acc;
        v = pc ^ (pc >> 3) ^ (pc >> 7) ^ hash;
        acc = '0;
        for (int i = 0; i < TAG_CHUNKS; i++) begin
            acc = acc ^ TAG_W'(v >> (i * TAG_W));
        end
        return acc;
    endfunction
endpackage

// File: design/store_dependence_path_table_top.sv
// Store dependence path table: a set-associative tagged table that maps a
// load pc and path hash to a predicted store pc.
// Input channel s_axis: cmd in tuser, load pc, path hash, store pc and
// mispredicted packed in tdata. Output channel m_axis: predicted_hit in
// tuser, predicted store pc in tdata, one result item per input item.
// From accept to result: the accept cycle reads the set from the way
// memories, then a lookup cycle and a compare and write cycle that loads
// the output register. Input stays blocked while a result waits in the
// output register, so a new item is accepted only once the last result is taken.
// A clear item sweeps the sets, one set a cycle, and its result comes
// after the last set is cleared.
// counter_max is written over the APB port, reset value 3.
// After reset the controller sweeps every set to zero, during which
// s_axis_tready stays low.
// When the receiver stalls, the result holds in the output register and no
// new item is accepted until it is taken.
module store_dependence_path_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: load pc[63:0], path hash[127:64], store pc[191:128], mispredicted[192]
    input  logic [199:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: predicted store pc[63:0]
    output logic [63:0]   m_axis_tdata,
    // tuser: predicted_hit[0]
    output logic          m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    sdpt_pkg::t_ctl ctl;
    logic res_load, hit;
    logic [63:0] pc;
    logic [3:0] r_cmax;
    logic r_ovalid;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {28'd0, r_cmax} : 32'd0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cmax <= sdpt_pkg::CMAX_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_cmax <= pwdata[3:0];
    end

    sdpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_in_cmd(s_axis_tuser), .i_out_busy(r_ovalid),
        .o_in_ready(s_axis_tready), .o_res_load(res_load), .o_ctl(ctl)
    );

    sdpt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_cmd(s_axis_tuser),
        .i_load_pc(s_axis_tdata[63:0]), .i_hash(s_axis_tdata[127:64]),
        .i_st_pc(s_axis_tdata[191:128]), .i_mispredicted(s_axis_tdata[192]),
        .i_counter_max(r_cmax), .o_hit(hit), .o_pc(pc)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (res_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
        if (res_load) begin
            m_axis_tdata <= ctl.update ? pc : 64'd0;
            m_axis_tuser <= ctl.update ? hit : 1'b0;
        end
    end
    assign m_axis_tvalid = r_ovalid;
endmodule

// File: design/sdpt_ctrl.sv
// controller state machine for the store dependence path table
// depends on sdpt_pkg and the macros header
`include "store_dependence_path_table_top_macros.svh"
module sdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_cmd,
    input  logic              i_out_busy,
    output logic              o_in_ready,
    output logic              o_res_load,
    output sdpt_pkg::t_ctl    o_ctl
);
    sdpt_pkg::t_state r_state, n_state;
    logic [sdpt_pkg::SET_W-1:0] r_cnt, n_cnt;
    logic r_clear, n_clear;

    assign o_in_ready = r_state == sdpt_pkg::ST_IDLE && !i_out_busy;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_clear = r_clear;
        o_res_load = 1'b0;
        o_ctl = '0;
        o_ctl.clr_set = r_cnt;
        unique case (r_state)
            sdpt_pkg::ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_ctl.capture = 1'b1;
                    n_clear = i_in_cmd == sdpt_pkg::CMD_CLEAR;
                    n_state = sdpt_pkg::ST_READ;
                end
            end
            sdpt_pkg::ST_READ: begin
                o_ctl.lookup = 1'b1;
                n_state = sdpt_pkg::ST_WRITE;
            end
            sdpt_pkg::ST_WRITE: begin
                if (r_clear) begin
                    n_cnt = '0;
                    n_state = sdpt_pkg::ST_CLEAR;
                end else begin
                    o_ctl.update = 1'b1;
                    o_res_load = 1'b1;
                    n_state = sdpt_pkg::ST_IDLE;
                end
            end
            // sweep of all sets: after reset, or for a clear item (result at the end)
            sdpt_pkg::ST_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    o_res_load = r_clear;
                    n_state = sdpt_pkg::ST_IDLE;
                end
            end
            default: n_state = sdpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdpt_pkg::ST_CLEAR;
            r_cnt <= '0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_clear <= n_clear;
        end
    end

    `SDPT_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `SDPT_ASSERT_NEXT(a_acc_read, i_clk, i_rst_n, o_ctl.capture, r_state == sdpt_pkg::ST_READ)
    `SDPT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == sdpt_pkg::ST_IDLE)
endmodule

// File: design/sdpt_dp.sv
// datapath: set memories, way compare, victim choice and use stamp
// depends on sdpt_pkg
module sdpt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdpt_pkg::t_ctl       i_ctl,
    input  logic [1:0]           i_cmd,
    input  logic [63:0]          i_load_pc,
    input  logic [63:0]          i_hash,
    input  logic [63:0]          i_st_pc,
    input  logic                 i_mispredicted,
    input  logic [3:0]           i_counter_max,
    output logic                 o_hit,
    output logic [63:0]          o_pc
);
    localparam int W = sdpt_pkg::WAYS;
    localparam int SB = sdpt_pkg::SET_W;
    localparam int TB = sdpt_pkg::TAG_W;
    localparam int WB = sdpt_pkg::WAY_BITS;

    // one memory per way, a word holds tag, conf, store pc, stamp
    typedef struct packed {
        logic [TB-1:0] tag;
        logic [3:0] conf;
        logic [63:0] spc;
        logic [63:0] stamp;
    } t_entry;

    t_entry mem [W][sdpt_pkg::NUM_SETS];
    t_entry r_rd [W];
    logic [1:0] r_cmd;
    logic [SB-1:0] r_set;
    logic [TB-1:0] r_tag;
    logic [63:0] r_spc;
    logic r_wrong;
    logic [63:0] r_use;

    // latch item and hash it
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_set <= sdpt_pkg::set_of(i_load_pc, i_hash);
            r_tag <= sdpt_pkg::tag_of(i_load_pc, i_hash);
            r_spc <= i_st_pc;
            r_wrong <= i_mispredicted;
        end
    end

    // match and victim over the registered set
    logic match;
    logic [WB-1:0] mway, vway, sel;
    t_entry rd [W];
    always_comb begin
        logic [63:0] best;
        for (int w = 0; w < W; w++) begin
            rd[w] = r_rd[w];
        end
        match = 1'b0;
        mway = '0;
        for (int w = W - 1; w >= 0; w--) begin
            if (rd[w].tag == r_tag) begin
                match = 1'b1;
                mway = WB'(w);
            end
        end
        vway = '0;
        best = rd[0].stamp;
        for (int w = 1; w < W; w++) begin
            if (rd[w].stamp < best) begin
                best = rd[w].stamp;
                vway = WB'(w);
            end
        end
        sel = match ? mway : vway;
    end

    t_entry cur, wr;
    logic do_wr, touch;
    always_comb begin
        cur = rd[sel];
        wr = cur;
        do_wr = 1'b0;
        o_hit = 1'b0;
        o_pc = '0;
        unique case (r_cmd)
            sdpt_pkg::CMD_PREDICT: begin
                if (match && cur.conf != 4'd0 && cur.spc != 64'd0) begin
                    do_wr = 1'b1;
                    o_hit = 1'b1;
                    o_pc = cur.spc;
                end
            end
            sdpt_pkg::CMD_VIOLATION: begin
                do_wr = 1'b1;
                wr.tag = r_tag;
                wr.spc = r_spc;
                wr.conf = i_counter_max;
            end
            sdpt_pkg::CMD_COMMIT: begin
                if (match && cur.conf != 4'd0) begin
                    do_wr = 1'b1;
                    wr.conf = r_wrong ? cur.conf - 4'd1 : i_counter_max;
                end
            end
            default: do_wr = 1'b0;
        endcase
        wr.stamp = r_use;
        touch = do_wr && i_ctl.update;
    end

    // memories: read on capture, write on update or clear
    always_ff @(posedge i_clk) begin
        for (int w = 0; w < W; w++) begin
            if (i_ctl.capture) begin
                r_rd[w] <= mem[w][sdpt_pkg::set_of(i_load_pc, i_hash)];
            end
            if (i_ctl.clr_wr) begin
                mem[w][i_ctl.clr_set] <= '0;
            end else if (touch && sel == WB'(w)) begin
                mem[w][r_set] <= wr;
            end
        end
    end

    // stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
        end else begin
            if (touch) r_use <= r_use + 64'd1;
        end
    end
endmodule

// File: test/tb.sv
// testbench for the store dependence path table: directed and random command
// streams checked against an in-bench table predictor; needs sdpt_pkg and the top level
`timescale 1ns / 1ps

module tb;
    localparam int NSETS = 1 << sdpt_pkg::SET_W;
    localparam int NENT = NSETS * sdpt_pkg::WAYS;
    localparam int WDOG_LIMIT = 6000;
    localparam int SETTLE = 2 * NSETS + 20;

    typedef struct packed {
        logic        hit;
        logic [63:0] spc;
    } t_outcome;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // tdata: load pc, path hash, store pc, mispredicted, zero fill
    logic [199:0]  s_axis_tdata;
    // tuser: cmd
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // tdata: predicted store pc
    logic [63:0]   m_axis_tdata;
    // tuser: predicted_hit
    logic          m_axis_tuser;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [1:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // shadow copy of the table
    logic [sdpt_pkg::TAG_W-1:0] tbl_tag [NENT];
    logic [63:0]                tbl_spc [NENT];
    logic [3:0]                 tbl_conf [NENT];
    logic [63:0]                tbl_stamp [NENT];
    logic [63:0]                stamp_now;
    logic [3:0]                 conf_max;

    t_outcome    pending_lookups[$];
    int          mismatches;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    int          items_sent;
    int          hits_seen;
    logic [63:0] key_pc [24];
    logic [63:0] key_hash [24];

    store_dependence_path_table_top u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [sdpt_pkg::SET_W-1:0] fold_set(logic [63:0] pc,
                                                            logic [63:0] hash);
        logic [63:0] v;
        logic [sdpt_pkg::SET_W-1:0] acc;
        v = pc ^ (pc >> 2) ^ (pc >> 5) ^ hash;
        acc = '0;
        while (v != 0) begin
            acc ^= v[sdpt_pkg::SET_W-1:0];
            v = v >> sdpt_pkg::SET_W;
        end
        return acc;
    endfunction

    function automatic logic [sdpt_pkg::TAG_W-1:0] fold_tag(logic [63:0] pc,
                                                            logic [63:0] hash);
        logic [63:0] v;
        logic [sdpt_pkg::TAG_W-1:0] acc;
        v = pc ^ (pc >> 3) ^ (pc >> 7) ^ hash;
        acc = '0;
        while (v != 0) begin
            acc ^= v[sdpt_pkg::TAG_W-1:0];
            v = v >> sdpt_pkg::TAG_W;
        end
        return acc;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // predicted outcome of one command, updating the shadow table
    function automatic t_outcome table_lookup_update(sdpt_pkg::t_cmd cmd, logic [63:0] pc,
                                                     logic [63:0] hash, logic [63:0] spc,
                                                     logic wrong);
        t_outcome res;
        int base;
        int found;
        int e;
        base = int'(fold_set(pc, hash)) * sdpt_pkg::WAYS;
        res = '0;
        found = -1;
        for (int w = sdpt_pkg::WAYS - 1; w >= 0; w--)
            if (tbl_tag[base + w] == fold_tag(pc, hash)) found = base + w;
        case (cmd)
            sdpt_pkg::CMD_PREDICT: begin
                if (found >= 0 && tbl_conf[found] != 0 && tbl_spc[found] != 0) begin
                    res.hit = 1'b1;
                    res.spc = tbl_spc[found];
                    tbl_stamp[found] = stamp_now;
                    stamp_now++;
                end
            end
            sdpt_pkg::CMD_VIOLATION: begin
                e = found;
                if (e < 0) begin
                    // least recently used, lowest way on ties
                    e = base;
                    for (int w = 1; w < sdpt_pkg::WAYS; w++)
                        if (tbl_stamp[base + w] < tbl_stamp[e]) e = base + w;
                    tbl_tag[e] = fold_tag(pc, hash);
                end
                tbl_spc[e] = spc;
                tbl_conf[e] = conf_max;
                tbl_stamp[e] = stamp_now;
                stamp_now++;
            end
            sdpt_pkg::CMD_COMMIT: begin
                if (found >= 0 && tbl_conf[found] != 0) begin
                    tbl_conf[found] = wrong ? tbl_conf[found] - 4'd1 : conf_max;
                    tbl_stamp[found] = stamp_now;
                    stamp_now++;
                end
            end
            default: begin
                for (int i = 0; i < NENT; i++) begin
                    tbl_tag[i] = '0;
                    tbl_spc[i] = '0;
                    tbl_conf[i] = '0;
                    tbl_stamp[i] = '0;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // send one item, predicting its result at the accepting edge
    task automatic send_item(sdpt_pkg::t_cmd cmd, logic [63:0] pc, logic [63:0] hash,
                             logic [63:0] spc, logic wrong);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {7'b0, wrong, spc, hash, pc};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_lookups.insert(pending_lookups.size(),
                               table_lookup_update(cmd, pc, hash, spc, wrong));
        items_sent++;
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write counter_max while the block is idle, then read it back
    task automatic write_conf_max(logic [3:0] value);
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {28'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        conf_max = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {28'b0, value})
            report_mismatch($sformatf("counter_max read %h, wrote %h", prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // keys spread at random over four sets, more keys than the ways of those sets
    task automatic make_key_pool();
        logic [sdpt_pkg::SET_W-1:0] target;
        for (int k = 0; k < 24; k++) begin
            target = sdpt_pkg::SET_W'($urandom_range(3) * 37);
            key_pc[k] = rand64();
            key_hash[k] = rand64();
            key_hash[k][sdpt_pkg::SET_W-1:0] ^= fold_set(key_pc[k], key_hash[k]) ^ target;
        end
    endtask

    task automatic test_directed();
        logic [63:0] pc;
        logic [63:0] hash;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        // empty entries: tag zero matches but never predicts, commit ignored
        send_item(sdpt_pkg::CMD_PREDICT, '0, '0, '0, 1'b0);
        send_item(sdpt_pkg::CMD_COMMIT, '0, '0, '0, 1'b1);
        // violation with zero store pc never predicts
        send_item(sdpt_pkg::CMD_VIOLATION, '0, '0, '0, 1'b0);
        send_item(sdpt_pkg::CMD_PREDICT, '0, '0, '0, 1'b0);
        // all-ones fields
        send_item(sdpt_pkg::CMD_VIOLATION, '1, '1, '1, 1'b1);
        send_item(sdpt_pkg::CMD_PREDICT, '1, '1, '0, 1'b1);
        send_item(sdpt_pkg::CMD_COMMIT, '1, '1, '1, 1'b1);
        send_item(sdpt_pkg::CMD_COMMIT, '1, '1, '1, 1'b0);
        send_item(sdpt_pkg::CMD_PREDICT, '1, '1, '1, 1'b0);
        // confidence runs out at counter_max 1
        write_conf_max(4'd1);
        send_item(sdpt_pkg::CMD_VIOLATION, 64'h1234, 64'h55, 64'hdead_beef, 1'b0);
        send_item(sdpt_pkg::CMD_COMMIT, 64'h1234, 64'h55, '0, 1'b1);
        send_item(sdpt_pkg::CMD_PREDICT, 64'h1234, 64'h55, '0, 1'b0);
        send_item(sdpt_pkg::CMD_COMMIT, 64'h1234, 64'h55, '0, 1'b0);
        // counter_max of zero leaves the entry unconfident
        write_conf_max(4'd0);
        send_item(sdpt_pkg::CMD_VIOLATION, 64'h777, 64'h9, 64'h4000, 1'b0);
        send_item(sdpt_pkg::CMD_PREDICT, 64'h777, 64'h9, '0, 1'b0);
        // six keys into one set exercise lru replacement
        write_conf_max(4'd15);
        for (int k = 0; k < 6; k++) begin
            pc = 64'h100 + k * 64'h10;
            hash = 64'(k) << 20;
            hash[sdpt_pkg::SET_W-1:0] ^= fold_set(pc, hash) ^ sdpt_pkg::SET_W'(5);
            send_item(sdpt_pkg::CMD_VIOLATION, pc, hash, pc + 64'h8, 1'b0);
        end
        send_item(sdpt_pkg::CMD_CLEAR, '0, '0, '0, 1'b0);
        send_item(sdpt_pkg::CMD_PREDICT, '1, '1, '0, 1'b0);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct, logic [3:0] cmax);
        int k;
        int r;
        sdpt_pkg::t_cmd cmd;
        write_conf_max(cmax);
        make_key_pool();
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            cmd = r < 45 ? sdpt_pkg::CMD_PREDICT : r < 72 ? sdpt_pkg::CMD_VIOLATION
                : r < 99 ? sdpt_pkg::CMD_COMMIT : sdpt_pkg::CMD_CLEAR;
            k = $urandom_range(23);
            if ($urandom_range(99) < 85)
                send_item(cmd, key_pc[k], key_hash[k],
                          $urandom_range(15) == 0 ? 64'd0 : rand64(),
                          1'($urandom_range(1)));
            else
                send_item(sdpt_pkg::t_cmd'($urandom_range(3)), rand64(), rand64(), rand64(),
                          1'($urandom_range(1)));
        end
    endtask

    // sender holds off until every result is back, then sends predicts to a receiver that stalls half the time
    task automatic test_quiet_pause();
        drain_results();
        sender_idle_pct = 0;
        recv_stall_pct = 50;
        for (int k = 0; k < 8; k++)
            send_item(sdpt_pkg::CMD_PREDICT, key_pc[k], key_hash[k], '0, 1'b0);
    endtask

    // receiver stalls and result check
    always @(posedge i_clk) begin
        t_outcome exp_out;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    exp_out = pending_lookups.pop_front();
                    hits_seen += exp_out.hit;
                    if (m_axis_tuser !== exp_out.hit)
                        report_mismatch($sformatf("hit %b, expected %b",
                                                  m_axis_tuser, exp_out.hit));
                    if (m_axis_tdata !== exp_out.spc)
                        report_mismatch($sformatf("store pc %h, expected %h",
                                                  m_axis_tdata, exp_out.spc));
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", pending_lookups.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        mismatches = 0;
        items_sent = 0;
        hits_seen = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        stamp_now = '0;
        conf_max = sdpt_pkg::CMAX_RESET;
        for (int i = 0; i < NENT; i++) begin
            tbl_tag[i] = '0;
            tbl_spc[i] = '0;
            tbl_conf[i] = '0;
            tbl_stamp[i] = '0;
        end
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400, 0, 0, 4'd3);
        test_random(400, 72, 0, 4'd15);
        test_quiet_pause();
        test_random(400, 0, 72, 4'd1);
        test_random(400, 26, 26, 4'd7);
        drain_results();

        $display("covered %0d items over counter_max 0, 1, 3, 7, 15 with idle and stall phases",
                 items_sent);
        $display("predict hits seen: %0d, mismatches: %0d", hits_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
